/* rtl/core/dn2d_pkg.sv */
// Shared constants and helper functions for the day number to date converter.
package dn2d_pkg;

   localparam int unsigned DayNrWidth = 22;
   localparam int unsigned YearWidth  = 14;
   localparam int unsigned MonthWidth = 4;
   localparam int unsigned DayWidth   = 5;
   localparam int unsigned DoyWidth   = 16;

   localparam logic [DayNrWidth-1:0] LowLimit  = 22'd365;
   localparam logic [DayNrWidth-1:0] HighLimit = 22'd3652500;

   // floor(2^34 / 1461); year estimate is floor(4 * day_number / 1461)
   localparam logic [23:0] YearRecip  = 24'd11758979;
   localparam int unsigned YearShift  = 34;
   localparam logic [10:0] QuadDays   = 11'd1461;

   // ceil(2^20 / 100), exact for 14-bit dividends
   localparam logic [13:0] CentRecip  = 14'd10486;
   localparam int unsigned CentShift  = 20;

   localparam logic signed [DoyWidth-1:0] CommonLen = 16'sd365;
   localparam logic signed [DoyWidth-1:0] LeapLen   = 16'sd366;
   localparam logic signed [DoyWidth-1:0] FebEnd    = 16'sd59;

   typedef logic [YearWidth-1:0]         year_type;
   typedef logic [MonthWidth-1:0]        month_type;
   typedef logic [DayWidth-1:0]          day_type;
   typedef logic signed [DoyWidth-1:0]   doy_type;

   // Days before the first of month m in a common year.
   function automatic doy_type month_start(input month_type m);
      doy_type s;
      unique case (m)
         4'd1:    s = 16'sd0;
         4'd2:    s = 16'sd31;
         4'd3:    s = 16'sd59;
         4'd4:    s = 16'sd90;
         4'd5:    s = 16'sd120;
         4'd6:    s = 16'sd151;
         4'd7:    s = 16'sd181;
         4'd8:    s = 16'sd212;
         4'd9:    s = 16'sd243;
         4'd10:   s = 16'sd273;
         4'd11:   s = 16'sd304;
         4'd12:   s = 16'sd334;
         default: s = 16'sd0;
      endcase
      return s;
   endfunction

   // Gregorian leap rule; year zero counts as common.
   function automatic logic is_leap(input year_type y);
      logic [27:0] prod;
      logic [7:0]  q;
      logic [14:0] qm;
      logic [14:0] rem;
      prod = y * CentRecip;
      q    = prod[27:20];
      qm   = q * 7'd100;
      rem  = {1'b0, y} - qm;
      return (y[1:0] == 2'b00) &&
             ((rem != 15'd0) || ((q[1:0] == 2'b00) && (y != '0)));
   endfunction

endpackage

/* rtl/core/dn2d_month_split.sv */
// Last two pipeline stages: leap day fixup, month search and day of month.
module dn2d_month_split (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  logic                in_range,
   input  logic                in_leap,
   input  dn2d_pkg::year_type  in_year,
   input  dn2d_pkg::doy_type   in_doy,
   output logic                out_valid,
   output dn2d_pkg::year_type  out_year,
   output dn2d_pkg::month_type out_month,
   output dn2d_pkg::day_type   out_day
);

   logic                valid_a_ff, valid_a_in;
   logic                range_a_ff, range_a_in;
   logic                leapday_a_ff, leapday_a_in;
   dn2d_pkg::year_type  year_a_ff, year_a_in;
   dn2d_pkg::doy_type   doy_a_ff, doy_a_in;
   dn2d_pkg::month_type month_a_ff, month_a_in;

   logic                valid_b_ff, valid_b_in;
   dn2d_pkg::year_type  year_b_ff, year_b_in;
   dn2d_pkg::month_type month_b_ff, month_b_in;
   dn2d_pkg::day_type   day_b_ff, day_b_in;

   dn2d_pkg::doy_type   doy_adj;
   dn2d_pkg::doy_type   day_full;

   always_comb begin
      doy_adj      = in_doy;
      leapday_a_in = 1'b0;
      if (in_leap && (in_doy > dn2d_pkg::FebEnd)) begin
         doy_adj      = in_doy - 16'sd1;
         leapday_a_in = (doy_adj == dn2d_pkg::FebEnd);
      end
      month_a_in = 4'd1;
      for (int m = 2; m <= 12; m++) begin
         if (doy_adj > dn2d_pkg::month_start(4'(m))) begin
            month_a_in = 4'(m);
         end
      end
      valid_a_in = in_valid;
      range_a_in = in_range;
      year_a_in  = in_year;
      doy_a_in   = doy_adj;
   end

   always_comb begin
      day_full   = doy_a_ff - dn2d_pkg::month_start(month_a_ff)
                   + {15'd0, leapday_a_ff};
      valid_b_in = valid_a_ff;
      if (range_a_ff) begin
         year_b_in  = year_a_ff;
         month_b_in = month_a_ff;
         day_b_in   = day_full[dn2d_pkg::DayWidth-1:0];
      end else begin
         year_b_in  = '0;
         month_b_in = '0;
         day_b_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else if (advance) begin
         valid_a_ff <= valid_a_in;
         valid_b_ff <= valid_b_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         range_a_ff   <= range_a_in;
         leapday_a_ff <= leapday_a_in;
         year_a_ff    <= year_a_in;
         doy_a_ff     <= doy_a_in;
         month_a_ff   <= month_a_in;
         year_b_ff    <= year_b_in;
         month_b_ff   <= month_b_in;
         day_b_ff     <= day_b_in;
      end
   end

   assign out_valid = valid_b_ff;
   assign out_year  = year_b_ff;
   assign out_month = month_b_ff;
   assign out_day   = day_b_ff;

endmodule

/* rtl/core/day_number_to_date.sv */
// An accepted req beat passes stages 1 to 7 and then month split stages a and b to its rsp beat.
// Throughput: one beat per cycle; the nine-stage pipeline moves as a whole and holds
// every stage while rsp_tvalid is high and rsp_tready is low.
// Each beat passes year estimate, century correction, two year-advance steps and the
// month search on its own stage.  Reset clears all stage valid bits; no clearing pass.
module day_number_to_date (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [21:0] day_number, [23:22] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [13:0] year, [17:14] month, [22:18] day, [23] zero
);

   logic advance;

   // stage 1: range check, reciprocal product
   logic                v1_ff, r1_ff, r1_in;
   logic [21:0]         dn1_ff;
   logic [47:0]         prod1_ff, prod1_in;
   // stage 2: quotient estimate times 1461
   logic                v2_ff, r2_ff;
   logic [21:0]         dn2_ff;
   logic [13:0]         q2_ff, q2_in;
   logic [24:0]         qm2_ff, qm2_in;
   // stage 3: quotient correction
   logic                v3_ff, r3_ff;
   logic [21:0]         dn3_ff;
   dn2d_pkg::year_type  y3_ff, y3_in;
   logic [24:0]         rem3;
   // stage 4: century quotient and leap flags
   logic                v4_ff, r4_ff;
   logic [21:0]         dn4_ff;
   dn2d_pkg::year_type  y4_ff, ym4_ff, ym4_in;
   logic [6:0]          c4_ff, c4_in;
   logic [2:0]          lp4_ff, lp4_in;
   logic [27:0]         cprod4;
   // stage 5: day of year
   logic                v5_ff, r5_ff;
   dn2d_pkg::year_type  y5_ff;
   dn2d_pkg::doy_type   d5_ff, d5_in;
   logic [2:0]          lp5_ff;
   logic [8:0]          cent5;
   logic [23:0]         diff5;
   // stage 6 and 7: year advance steps
   logic                v6_ff, r6_ff, v7_ff, r7_ff;
   dn2d_pkg::year_type  y6_ff, y6_in, y7_ff, y7_in;
   dn2d_pkg::doy_type   d6_ff, d6_in, d7_ff, d7_in;
   logic [1:0]          lp6_ff, lp6_in;
   logic                lp7_ff, lp7_in;
   dn2d_pkg::doy_type   len5, len6;

   logic                out_valid;
   dn2d_pkg::year_type  out_year;
   dn2d_pkg::month_type out_month;
   dn2d_pkg::day_type   out_day;

   assign advance    = rsp_tready || !out_valid;
   assign req_tready = advance;

   always_comb begin
      r1_in    = (req_tdata[21:0] > dn2d_pkg::LowLimit) &&
                 (req_tdata[21:0] < dn2d_pkg::HighLimit);
      prod1_in = {req_tdata[21:0], 2'b00} * dn2d_pkg::YearRecip;

      q2_in    = prod1_ff[47:34];
      qm2_in   = q2_in * dn2d_pkg::QuadDays;

      rem3     = {1'b0, dn2_ff, 2'b00} - qm2_ff;
      y3_in    = (rem3 >= 25'(dn2d_pkg::QuadDays)) ? q2_ff + 14'd1 : q2_ff;

      ym4_in   = y3_ff - 14'd1;
      cprod4   = ym4_in * dn2d_pkg::CentRecip;
      c4_in    = cprod4[26:20];
      lp4_in   = {dn2d_pkg::is_leap(y3_ff + 14'd2),
                  dn2d_pkg::is_leap(y3_ff + 14'd1),
                  dn2d_pkg::is_leap(y3_ff)};

      cent5    = ({2'b00, c4_ff} + 9'd1) * 9'd3;
      diff5    = {2'b00, dn4_ff} - (y4_ff * 10'd365) - {12'd0, ym4_ff[13:2]}
                 + {17'd0, cent5[8:2]};
      d5_in    = diff5[dn2d_pkg::DoyWidth-1:0];

      len5     = lp5_ff[0] ? dn2d_pkg::LeapLen : dn2d_pkg::CommonLen;
      if (d5_ff > len5) begin
         d6_in  = d5_ff - len5;
         y6_in  = y5_ff + 14'd1;
         lp6_in = lp5_ff[2:1];
      end else begin
         d6_in  = d5_ff;
         y6_in  = y5_ff;
         lp6_in = lp5_ff[1:0];
      end

      len6     = lp6_ff[0] ? dn2d_pkg::LeapLen : dn2d_pkg::CommonLen;
      if (d6_ff > len6) begin
         d7_in  = d6_ff - len6;
         y7_in  = y6_ff + 14'd1;
         lp7_in = lp6_ff[1];
      end else begin
         d7_in  = d6_ff;
         y7_in  = y6_ff;
         lp7_in = lp6_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         v7_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
         v7_ff <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         r1_ff    <= r1_in;
         dn1_ff   <= req_tdata[21:0];
         prod1_ff <= prod1_in;
         r2_ff    <= r1_ff;
         dn2_ff   <= dn1_ff;
         q2_ff    <= q2_in;
         qm2_ff   <= qm2_in;
         r3_ff    <= r2_ff;
         dn3_ff   <= dn2_ff;
         y3_ff    <= y3_in;
         r4_ff    <= r3_ff;
         dn4_ff   <= dn3_ff;
         y4_ff    <= y3_ff;
         ym4_ff   <= ym4_in;
         c4_ff    <= c4_in;
         lp4_ff   <= lp4_in;
         r5_ff    <= r4_ff;
         y5_ff    <= y4_ff;
         d5_ff    <= d5_in;
         lp5_ff   <= lp4_ff;
         r6_ff    <= r5_ff;
         y6_ff    <= y6_in;
         d6_ff    <= d6_in;
         lp6_ff   <= lp6_in;
         r7_ff    <= r6_ff;
         y7_ff    <= y7_in;
         d7_ff    <= d7_in;
         lp7_ff   <= lp7_in;
      end
   end

   dn2d_month_split u_month_split (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (v7_ff),
      .in_range  (r7_ff),
      .in_leap   (lp7_ff),
      .in_year   (y7_ff),
      .in_doy    (d7_ff),
      .out_valid (out_valid),
      .out_year  (out_year),
      .out_month (out_month),
      .out_day   (out_day)
   );

   assign rsp_tvalid = out_valid;
   assign rsp_tdata  = {1'b0, out_day, out_month, out_year};

endmodule
